@@ design/sel_lex_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sel_lex_pkg
// shared types, token codes, reserved-word table and character classes
// for the selector expression lexer
// ----------------------------------------------------------------------------
package sel_lex_pkg;

  // width of the stream offset counter
  localparam int OFFSET_BITS = 16;

  localparam int NUM_WORDS   = 11;
  localparam int WORD_MAXLEN = 7;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // token codes
  localparam logic [4:0] TT_END       = 5'd0;
  localparam logic [4:0] TT_LPAREN    = 5'd1;
  localparam logic [4:0] TT_RPAREN    = 5'd2;
  localparam logic [4:0] TT_COMMA     = 5'd3;
  localparam logic [4:0] TT_PLUS      = 5'd4;
  localparam logic [4:0] TT_MINUS     = 5'd5;
  localparam logic [4:0] TT_MUL       = 5'd6;
  localparam logic [4:0] TT_DIV       = 5'd7;
  localparam logic [4:0] TT_EQ        = 5'd8;
  localparam logic [4:0] TT_LT        = 5'd9;
  localparam logic [4:0] TT_NE        = 5'd10;
  localparam logic [4:0] TT_LE        = 5'd11;
  localparam logic [4:0] TT_GT        = 5'd12;
  localparam logic [4:0] TT_GE        = 5'd13;
  localparam logic [4:0] TT_IDENT     = 5'd14;
  localparam logic [4:0] TT_STRING    = 5'd15;
  localparam logic [4:0] TT_EXACT     = 5'd16;
  localparam logic [4:0] TT_APPROX    = 5'd17;
  localparam logic [4:0] TT_WORD_BASE = 5'd18;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  // reserved words, right-justified ascii
  localparam logic [8*WORD_MAXLEN-1:0] WORD_TEXT [NUM_WORDS] = '{
    "and", "between", "escape", "false", "in", "is",
    "like", "not", "null", "or", "true"
  };
  localparam logic [2:0] WORD_LEN [NUM_WORDS] = '{
    3'd3, 3'd7, 3'd6, 3'd5, 3'd2, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4
  };

  typedef enum logic [4:0] {
    ST_START, ST_IDENT, ST_LT, ST_GT, ST_ZERO, ST_OCT, ST_DIGIT, ST_DEC_START,
    ST_DEC, ST_EXP_SIGN, ST_EXP_START, ST_EXP, ST_HEX_START, ST_HEX,
    ST_BIN_START, ST_BIN, ST_STR, ST_STR_Q
  } lex_state_e;

  typedef enum logic [1:0] {
    ACT_TAKE, ACT_INC, ACT_NOINC, ACT_FAIL
  } pend_act_e;

  typedef struct packed {
    logic        last;
    logic [15:0] length;
    logic [15:0] start;
    logic        error;
    logic [4:0]  ttype;
  } result_t;

  // what one lexer step hands to the result queue
  typedef struct packed {
    logic [1:0] count;
    result_t    r1;
    result_t    r0;
  } step_out_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_xdigit(logic [7:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_ident_char(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == "_") || (c == "$") || (c == ".");
  endfunction

  function automatic logic is_fd(logic [7:0] c);
    return (c == "f") || (c == "F") || (c == "d") || (c == "D");
  endfunction

  function automatic logic is_l(logic [7:0] c);
    return (c == "l") || (c == "L");
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
  endfunction

  // character idx of reserved word w, zero beyond its length
  function automatic logic [7:0] word_char(int w, logic [2:0] idx);
    int sh;
    sh = 8 * (int'(WORD_LEN[w]) - 1 - int'(idx));
    if (idx < WORD_LEN[w]) begin
      return WORD_TEXT[w][sh +: 8];
    end
    return 8'd0;
  endfunction

  // single character operators, TT_END when none
  function automatic logic [4:0] single_op_type(logic [7:0] c);
    logic [4:0] t;
    case (c)
      "(":     t = TT_LPAREN;
      ")":     t = TT_RPAREN;
      ",":     t = TT_COMMA;
      "+":     t = TT_PLUS;
      "-":     t = TT_MINUS;
      "*":     t = TT_MUL;
      "/":     t = TT_DIV;
      "=":     t = TT_EQ;
      default: t = TT_END;
    endcase
    return t;
  endfunction

  // offset counter to the 16-bit result field
  function automatic logic [15:0] off_to_field(logic [OFFSET_BITS-1:0] p);
    logic [OFFSET_BITS+15:0] wide;
    wide = {16'd0, p};
    return wide[15:0];
  endfunction

endpackage

@@ design/sel_lex_words.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sel_lex_words
// caseless reserved-word matcher: narrows the candidate mask by one
// character and classifies the identifier collected so far
// ----------------------------------------------------------------------------
module sel_lex_words (
  input  logic        restart_i,
  input  logic [10:0] cand_i,
  input  logic [2:0]  idx_i,
  input  logic [7:0]  char_i,
  output logic [10:0] cand_o,
  output logic [2:0]  idx_o,
  output logic [4:0]  ident_type_o
);

  logic [10:0] base_cand;
  logic [2:0]  base_idx;
  logic [7:0]  lc;

  always_comb begin
    base_cand = restart_i ? '1 : cand_i;
    base_idx  = restart_i ? 3'd0 : idx_i;
    lc        = sel_lex_pkg::to_lower(char_i);
    for (int w = 0; w < sel_lex_pkg::NUM_WORDS; w++) begin
      cand_o[w] = base_cand[w] && (base_idx != 3'd7) &&
                  (base_idx < sel_lex_pkg::WORD_LEN[w]) &&
                  (sel_lex_pkg::word_char(w, base_idx) == lc);
    end
    idx_o = (base_idx == 3'd7) ? base_idx : base_idx + 3'd1;
  end

  // lowest surviving word of matching length wins
  always_comb begin
    ident_type_o = sel_lex_pkg::TT_IDENT;
    for (int w = sel_lex_pkg::NUM_WORDS - 1; w >= 0; w--) begin
      if (cand_i[w] && (sel_lex_pkg::WORD_LEN[w] == idx_i)) begin
        ident_type_o = sel_lex_pkg::TT_WORD_BASE + 5'(w);
      end
    end
  end

endmodule

@@ design/sel_lex_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sel_lex_core
// lexer state registers and the one-character transition step
// ----------------------------------------------------------------------------
module sel_lex_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  cmd_i,
  input  logic [7:0]            char_i,
  output sel_lex_pkg::step_out_t out_o
);

  sel_lex_pkg::lex_state_e st_q, st_d, take_st;
  logic [sel_lex_pkg::OFFSET_BITS-1:0] pos_q, pos_d, beg_q, beg_d;
  logic [15:0] cnt_q, cnt_d, cnt_inc;
  logic [10:0] cand_q, cand_d, cand_upd;
  logic [2:0]  widx_q, widx_d, widx_upd;
  logic        qkind_q, qkind_d, halt_q, halt_d;

  sel_lex_pkg::pend_act_e act;
  logic [4:0]  ptype, ident_type, op_type;
  logic [7:0]  quote_char;
  logic        word_restart;
  logic        relex, fail, clear_all;
  logic        pend_vld, tail_vld;
  sel_lex_pkg::result_t pend_res, tail_res;
  logic [15:0] pos_f, beg_f;

  assign quote_char   = qkind_q ? 8'h22 : 8'h27;
  assign word_restart = (st_q == sel_lex_pkg::ST_START) || (act == sel_lex_pkg::ACT_NOINC);
  assign pos_f        = sel_lex_pkg::off_to_field(pos_q);
  assign beg_f        = sel_lex_pkg::off_to_field(beg_q);
  assign op_type      = sel_lex_pkg::single_op_type(char_i);

  sel_lex_words u_words (
    .restart_i    (word_restart),
    .cand_i       (cand_q),
    .idx_i        (widx_q),
    .char_i       (char_i),
    .cand_o       (cand_upd),
    .idx_o        (widx_upd),
    .ident_type_o (ident_type)
  );

  // decision for a character arriving while a token is pending
  always_comb begin
    act     = sel_lex_pkg::ACT_TAKE;
    ptype   = sel_lex_pkg::TT_END;
    take_st = st_q;
    case (st_q)
      sel_lex_pkg::ST_IDENT: begin
        if (!sel_lex_pkg::is_ident_char(char_i)) begin
          act   = sel_lex_pkg::ACT_NOINC;
          ptype = ident_type;
        end
      end
      sel_lex_pkg::ST_LT: begin
        if (char_i == ">") begin
          act = sel_lex_pkg::ACT_INC; ptype = sel_lex_pkg::TT_NE;
        end else if (char_i == "=") begin
          act = sel_lex_pkg::ACT_INC; ptype = sel_lex_pkg::TT_LE;
        end else begin
          act = sel_lex_pkg::ACT_NOINC; ptype = sel_lex_pkg::TT_LT;
        end
      end
      sel_lex_pkg::ST_GT: begin
        if (char_i == "=") begin
          act = sel_lex_pkg::ACT_INC; ptype = sel_lex_pkg::TT_GE;
        end else begin
          act = sel_lex_pkg::ACT_NOINC; ptype = sel_lex_pkg::TT_GT;
        end
      end
      sel_lex_pkg::ST_ZERO, sel_lex_pkg::ST_OCT: begin
        if ((st_q == sel_lex_pkg::ST_ZERO) && (char_i == ".")) begin
          take_st = sel_lex_pkg::ST_DEC;
        end else if ((st_q == sel_lex_pkg::ST_ZERO) && ((char_i == "x") || (char_i == "X")))
        begin
          take_st = sel_lex_pkg::ST_HEX_START;
        end else if ((st_q == sel_lex_pkg::ST_ZERO) && ((char_i == "b") || (char_i == "B")))
        begin
          take_st = sel_lex_pkg::ST_BIN_START;
        end else if (sel_lex_pkg::is_l(char_i)) begin
          act = sel_lex_pkg::ACT_INC; ptype = sel_lex_pkg::TT_EXACT;
        end else if (((char_i >= "0") && (char_i <= "7")) || (char_i == "_")) begin
          take_st = sel_lex_pkg::ST_OCT;
        end else begin
          act = sel_lex_pkg::ACT_NOINC; ptype = sel_lex_pkg::TT_EXACT;
        end
      end
      sel_lex_pkg::ST_DIGIT: begin
        if (sel_lex_pkg::is_l(char_i)) begin
          act = sel_lex_pkg::ACT_INC; ptype = sel_lex_pkg::TT_EXACT;
        end else if (sel_lex_pkg::is_fd(char_i)) begin
          act = sel_lex_pkg::ACT_INC; ptype = sel_lex_pkg::TT_APPROX;
        end else if (sel_lex_pkg::is_digit(char_i) || (char_i == "_")) begin
          take_st = sel_lex_pkg::ST_DIGIT;
        end else if (char_i == ".") begin
          take_st = sel_lex_pkg::ST_DEC;
        end else if ((char_i == "e") || (char_i == "E")) begin
          take_st = sel_lex_pkg::ST_EXP_SIGN;
        end else begin
          act = sel_lex_pkg::ACT_NOINC; ptype = sel_lex_pkg::TT_EXACT;
        end
      end
      sel_lex_pkg::ST_DEC_START: begin
        if (sel_lex_pkg::is_digit(char_i)) take_st = sel_lex_pkg::ST_DEC;
        else act = sel_lex_pkg::ACT_FAIL;
      end
      sel_lex_pkg::ST_DEC: begin
        if (sel_lex_pkg::is_digit(char_i) || (char_i == "_")) begin
          take_st = sel_lex_pkg::ST_DEC;
        end else if ((char_i == "e") || (char_i == "E")) begin
          take_st = sel_lex_pkg::ST_EXP_SIGN;
        end else if (sel_lex_pkg::is_fd(char_i)) begin
          act = sel_lex_pkg::ACT_INC; ptype = sel_lex_pkg::TT_APPROX;
        end else begin
          act = sel_lex_pkg::ACT_NOINC; ptype = sel_lex_pkg::TT_APPROX;
        end
      end
      sel_lex_pkg::ST_EXP_SIGN: begin
        if ((char_i == "+") || (char_i == "-")) take_st = sel_lex_pkg::ST_EXP_START;
        else if (sel_lex_pkg::is_digit(char_i)) take_st = sel_lex_pkg::ST_EXP;
        else act = sel_lex_pkg::ACT_FAIL;
      end
      sel_lex_pkg::ST_EXP_START: begin
        if (sel_lex_pkg::is_digit(char_i)) take_st = sel_lex_pkg::ST_EXP;
        else act = sel_lex_pkg::ACT_FAIL;
      end
      sel_lex_pkg::ST_EXP: begin
        if (!sel_lex_pkg::is_digit(char_i)) begin
          ptype = sel_lex_pkg::TT_APPROX;
          act   = sel_lex_pkg::is_fd(char_i) ? sel_lex_pkg::ACT_INC : sel_lex_pkg::ACT_NOINC;
        end
      end
      sel_lex_pkg::ST_HEX_START: begin
        if (sel_lex_pkg::is_xdigit(char_i)) take_st = sel_lex_pkg::ST_HEX;
        else act = sel_lex_pkg::ACT_FAIL;
      end
      sel_lex_pkg::ST_HEX: begin
        if (sel_lex_pkg::is_l(char_i)) begin
          act = sel_lex_pkg::ACT_INC; ptype = sel_lex_pkg::TT_EXACT;
        end else if (sel_lex_pkg::is_xdigit(char_i) || (char_i == "_")) begin
          take_st = sel_lex_pkg::ST_HEX;
        end else if ((char_i == "p") || (char_i == "P")) begin
          take_st = sel_lex_pkg::ST_EXP_SIGN;
        end else begin
          act = sel_lex_pkg::ACT_NOINC; ptype = sel_lex_pkg::TT_EXACT;
        end
      end
      sel_lex_pkg::ST_BIN_START: begin
        if ((char_i == "0") || (char_i == "1")) take_st = sel_lex_pkg::ST_BIN;
        else act = sel_lex_pkg::ACT_FAIL;
      end
      sel_lex_pkg::ST_BIN: begin
        if (sel_lex_pkg::is_l(char_i)) begin
          act = sel_lex_pkg::ACT_INC; ptype = sel_lex_pkg::TT_EXACT;
        end else if ((char_i == "0") || (char_i == "1") || (char_i == "_")) begin
          take_st = sel_lex_pkg::ST_BIN;
        end else begin
          act = sel_lex_pkg::ACT_NOINC; ptype = sel_lex_pkg::TT_EXACT;
        end
      end
      sel_lex_pkg::ST_STR: begin
        take_st = (char_i == quote_char) ? sel_lex_pkg::ST_STR_Q : sel_lex_pkg::ST_STR;
      end
      sel_lex_pkg::ST_STR_Q: begin
        if (char_i == quote_char) begin
          take_st = sel_lex_pkg::ST_STR;
        end else begin
          act   = sel_lex_pkg::ACT_NOINC;
          ptype = qkind_q ? sel_lex_pkg::TT_IDENT : sel_lex_pkg::TT_STRING;
        end
      end
      default: act = sel_lex_pkg::ACT_FAIL;
    endcase
  end

  // step: pending-token result first, then the freshly lexed or end result
  always_comb begin
    st_d      = st_q;
    pos_d     = pos_q;
    beg_d     = beg_q;
    cnt_d     = cnt_q;
    cand_d    = cand_q;
    widx_d    = widx_q;
    qkind_d   = qkind_q;
    halt_d    = halt_q;
    pend_vld  = 1'b0;
    tail_vld  = 1'b0;
    pend_res  = '0;
    tail_res  = '0;
    relex     = 1'b0;
    fail      = 1'b0;
    clear_all = 1'b0;
    cnt_inc   = (cnt_q != sel_lex_pkg::CNT_MAX) ? cnt_q + 16'd1 : cnt_q;
    pend_res.start  = beg_f;
    pend_res.length = cnt_q;

    if (step_i) begin
      if (halt_q) begin
        clear_all = cmd_i;
      end else if (cmd_i) begin
        pend_vld = 1'b1;
        case (st_q)
          sel_lex_pkg::ST_START: pend_vld = 1'b0;
          sel_lex_pkg::ST_IDENT: pend_res.ttype = ident_type;
          sel_lex_pkg::ST_LT:    pend_res.ttype = sel_lex_pkg::TT_LT;
          sel_lex_pkg::ST_GT:    pend_res.ttype = sel_lex_pkg::TT_GT;
          sel_lex_pkg::ST_ZERO, sel_lex_pkg::ST_OCT, sel_lex_pkg::ST_DIGIT,
          sel_lex_pkg::ST_HEX, sel_lex_pkg::ST_BIN:
            pend_res.ttype = sel_lex_pkg::TT_EXACT;
          sel_lex_pkg::ST_DEC, sel_lex_pkg::ST_EXP:
            pend_res.ttype = sel_lex_pkg::TT_APPROX;
          sel_lex_pkg::ST_STR_Q:
            pend_res.ttype = qkind_q ? sel_lex_pkg::TT_IDENT : sel_lex_pkg::TT_STRING;
          default: begin
            // dangling literal
            fail           = 1'b1;
            pend_res.error = 1'b1;
          end
        endcase
        if (!fail) begin
          tail_vld       = 1'b1;
          tail_res.ttype = sel_lex_pkg::TT_END;
          tail_res.start = pos_f;
        end
        clear_all = 1'b1;
      end else begin
        pos_d = pos_q + 1'b1;
        if (st_q == sel_lex_pkg::ST_START) begin
          relex = 1'b1;
        end else begin
          case (act)
            sel_lex_pkg::ACT_TAKE: begin
              st_d  = take_st;
              cnt_d = cnt_inc;
              if (st_q == sel_lex_pkg::ST_IDENT) begin
                cand_d = cand_upd;
                widx_d = widx_upd;
              end
            end
            sel_lex_pkg::ACT_INC: begin
              cnt_d           = cnt_inc;
              pend_vld        = 1'b1;
              pend_res.ttype  = ptype;
              pend_res.length = cnt_inc;
              st_d            = sel_lex_pkg::ST_START;
            end
            sel_lex_pkg::ACT_NOINC: begin
              pend_vld       = 1'b1;
              pend_res.ttype = ptype;
              st_d           = sel_lex_pkg::ST_START;
              relex          = 1'b1;
            end
            default: begin
              // malformed number
              cnt_d           = cnt_inc;
              pend_vld        = 1'b1;
              pend_res.error  = 1'b1;
              pend_res.length = cnt_inc;
              st_d            = sel_lex_pkg::ST_START;
              halt_d          = 1'b1;
            end
          endcase
        end

        if (relex && !sel_lex_pkg::is_space(char_i)) begin
          tail_res.start  = pos_f;
          tail_res.length = 16'd1;
          if (op_type != sel_lex_pkg::TT_END) begin
            tail_vld       = 1'b1;
            tail_res.ttype = op_type;
          end else if (char_i == "<") begin
            st_d = sel_lex_pkg::ST_LT;  beg_d = pos_q; cnt_d = 16'd1;
          end else if (char_i == ">") begin
            st_d = sel_lex_pkg::ST_GT;  beg_d = pos_q; cnt_d = 16'd1;
          end else if (sel_lex_pkg::is_alpha(char_i) || (char_i == "_") || (char_i == "$"))
          begin
            st_d   = sel_lex_pkg::ST_IDENT;
            beg_d  = pos_q;
            cnt_d  = 16'd1;
            cand_d = cand_upd;
            widx_d = widx_upd;
          end else if ((char_i == 8'h27) || (char_i == 8'h22)) begin
            st_d    = sel_lex_pkg::ST_STR;
            beg_d   = pos_q;
            cnt_d   = 16'd1;
            qkind_d = (char_i == 8'h22);
          end else if (char_i == "0") begin
            st_d = sel_lex_pkg::ST_ZERO; beg_d = pos_q; cnt_d = 16'd1;
          end else if (sel_lex_pkg::is_digit(char_i)) begin
            st_d = sel_lex_pkg::ST_DIGIT; beg_d = pos_q; cnt_d = 16'd1;
          end else if (char_i == ".") begin
            st_d = sel_lex_pkg::ST_DEC_START; beg_d = pos_q; cnt_d = 16'd1;
          end else begin
            // illegal character
            tail_vld       = 1'b1;
            tail_res.ttype = sel_lex_pkg::TT_END;
            tail_res.error = 1'b1;
            halt_d         = 1'b1;
          end
        end
      end
    end

    if (clear_all) begin
      st_d    = sel_lex_pkg::ST_START;
      pos_d   = '0;
      beg_d   = '0;
      cnt_d   = '0;
      cand_d  = '1;
      widx_d  = '0;
      qkind_d = 1'b0;
      halt_d  = 1'b0;
    end
  end

  // pack results in emission order, last on the final one
  always_comb begin
    out_o = '0;
    if (pend_vld) begin
      out_o.r0      = pend_res;
      out_o.r0.last = !tail_vld;
      out_o.r1      = tail_res;
      out_o.r1.last = 1'b1;
      out_o.count   = tail_vld ? 2'd2 : 2'd1;
    end else if (tail_vld) begin
      out_o.r0      = tail_res;
      out_o.r0.last = 1'b1;
      out_o.count   = 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= sel_lex_pkg::ST_START;
      pos_q   <= '0;
      beg_q   <= '0;
      cnt_q   <= '0;
      cand_q  <= '1;
      widx_q  <= '0;
      qkind_q <= 1'b0;
      halt_q  <= 1'b0;
    end else begin
      st_q    <= st_d;
      pos_q   <= pos_d;
      beg_q   <= beg_d;
      cnt_q   <= cnt_d;
      cand_q  <= cand_d;
      widx_q  <= widx_d;
      qkind_q <= qkind_d;
      halt_q  <= halt_d;
    end
  end

endmodule

@@ design/sel_lex_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sel_lex_fifo
// small result queue: takes up to two results per cycle, hands out one
// ----------------------------------------------------------------------------
module sel_lex_fifo (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sel_lex_pkg::step_out_t              push_i,
  input  logic                                pop_i,
  output sel_lex_pkg::result_t                head_o,
  output logic                                valid_o,
  output logic [sel_lex_pkg::FIFO_CNT_W-1:0]  count_o
);

  sel_lex_pkg::result_t mem [sel_lex_pkg::FIFO_DEPTH];

  logic [sel_lex_pkg::FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [sel_lex_pkg::FIFO_CNT_W-1:0] count_q, count_d;
  logic [sel_lex_pkg::FIFO_PTR_W-1:0] wr_ptr_nx;

  assign wr_ptr_nx = wr_ptr_q + 1'b1;
  assign head_o    = mem[rd_ptr_q];
  assign valid_o   = (count_q != '0);
  assign count_o   = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q + sel_lex_pkg::FIFO_PTR_W'(push_i.count);
    rd_ptr_d = rd_ptr_q + sel_lex_pkg::FIFO_PTR_W'(pop_i);
    count_d  = count_q + sel_lex_pkg::FIFO_CNT_W'(push_i.count)
                       - sel_lex_pkg::FIFO_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.count == 2'd2) begin
      mem[wr_ptr_nx] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

@@ design/selector_expression_lexer_unit.sv @@
`timescale 1ns / 1ps
// throughput: one request per cycle while results keep pace; the step only runs with two
//   queue entries free and the result side moves one per cycle, so requests that each
//   yield two results (pending token plus one of their own) cannot go in back to back
// reset: rst_ni low clears lexer state, offset counter, input stage and queue at once
// ----------------------------------------------------------------------------
// selector_expression_lexer_unit
// streaming lexer for selector expressions, one character per request
// ----------------------------------------------------------------------------
module selector_expression_lexer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] character
  input  logic        s_axis_tuser_i,   // [0] cmd (1 = end of expression)
  // result side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [4:0] token_type, [20:5] token_start,
                                        // [36:21] token_length, [39:37] zero
  output logic        m_axis_tuser_o,   // [0] error
  output logic        m_axis_tlast_o    // last result of the request
);

  // input register: holds one request until the lexer step takes it
  logic       in_valid_q, in_valid_d;
  logic       in_cmd_q;
  logic [7:0] in_char_q;

  logic                                in_take;
  logic                                advance;
  logic                                room;
  sel_lex_pkg::step_out_t              step_out;
  sel_lex_pkg::result_t                head;
  logic                                head_valid;
  logic                                pop;
  logic [sel_lex_pkg::FIFO_CNT_W-1:0]  fifo_count;

  // the step may push two results, so it only runs while two entries are free;
  // this keeps the request side free of any combinational path from m_axis_tready_i
  assign room    = (fifo_count <= sel_lex_pkg::FIFO_CNT_W'(sel_lex_pkg::FIFO_DEPTH - 2));
  assign advance = in_valid_q && room;

  // a new request can land in the same cycle the held one moves on
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_cmd_q  <= s_axis_tuser_i;
      in_char_q <= s_axis_tdata_i;
    end
  end

  // lexer state and one-character transition
  sel_lex_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .cmd_i  (in_cmd_q),
    .char_i (in_char_q),
    .out_o  (step_out)
  );

  // result queue doubles as the output register
  sel_lex_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step_out),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (head_valid),
    .count_o (fifo_count)
  );

  assign pop             = head_valid && m_axis_tready_i;
  assign m_axis_tvalid_o = head_valid;
  assign m_axis_tdata_o  = {3'b000, head.length, head.start, head.ttype};
  assign m_axis_tuser_o  = head.error;
  assign m_axis_tlast_o  = head.last;

`ifndef SYNTH
  // the queue never overfills
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_count <= sel_lex_pkg::FIFO_CNT_W'(sel_lex_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // a two-result step marks only the second as last
  a_pair_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_out.count == 2'd2) |-> (!step_out.r0.last && step_out.r1.last))
    else $error("two-result step has wrong last marking");

  // errors and end tokens always close their request, errors carry the end code
  a_error_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_valid && head.error) |-> (head.last && (head.ttype == sel_lex_pkg::TT_END)))
    else $error("error result not final or not typed as end");

  a_end_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_valid && (head.ttype == sel_lex_pkg::TT_END)) |-> head.last)
    else $error("end token not marked last");
`endif

endmodule

@@ test/lexer_token_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lexer_token_checker
// watches both streams of the selector expression lexer, predicts the tokens
// of every accepted request and compares each result with the oldest one due
// ----------------------------------------------------------------------------
module lexer_token_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [7:0]  req_char_i,
  input  logic        req_end_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [39:0] res_data_i,
  input  logic        res_error_i,
  input  logic        res_last_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          requests_o,
  output int          results_o,
  output int          error_results_o
);

  typedef struct packed {
    logic [4:0]  kind;
    logic        err;
    logic [15:0] start;
    logic [15:0] span;
    logic        last;
  } token_t;

  string reserved [sel_lex_pkg::NUM_WORDS] = '{
    "and", "between", "escape", "false", "in", "is",
    "like", "not", "null", "or", "true"
  };

  token_t tokens_due [$];

  // predicted lexer state
  sel_lex_pkg::lex_state_e                  st;
  logic [sel_lex_pkg::OFFSET_BITS-1:0]      pos;
  logic [sel_lex_pkg::OFFSET_BITS-1:0]      tok_begin;
  logic [15:0]                              tok_len;
  logic [sel_lex_pkg::NUM_WORDS-1:0]        word_mask;
  logic [2:0]                               word_idx;
  logic                                     dquote;
  logic                                     halted;

  int fails;
  int requests;
  int results;
  int error_results;

  function automatic logic digit_ch(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic letter_ch(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic hex_ch(logic [7:0] c);
    return digit_ch(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic blank_ch(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic fd_ch(logic [7:0] c);
    return c == "f" || c == "F" || c == "d" || c == "D";
  endfunction

  function automatic logic long_ch(logic [7:0] c);
    return c == "l" || c == "L";
  endfunction

  function automatic logic [7:0] fold_case(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic [4:0] single_char_op(logic [7:0] c);
    case (c)
      "(":     return sel_lex_pkg::TT_LPAREN;
      ")":     return sel_lex_pkg::TT_RPAREN;
      ",":     return sel_lex_pkg::TT_COMMA;
      "+":     return sel_lex_pkg::TT_PLUS;
      "-":     return sel_lex_pkg::TT_MINUS;
      "*":     return sel_lex_pkg::TT_MUL;
      "/":     return sel_lex_pkg::TT_DIV;
      "=":     return sel_lex_pkg::TT_EQ;
      default: return sel_lex_pkg::TT_END;
    endcase
  endfunction

  // reserved word still matching with exactly the length seen, else plain identifier
  function automatic logic [4:0] word_kind();
    string w;
    int k;
    for (k = 0; k < sel_lex_pkg::NUM_WORDS; k++) begin
      w = reserved[k];
      if (word_mask[k] && w.len() == int'(word_idx)) return sel_lex_pkg::TT_WORD_BASE + 5'(k);
    end
    return sel_lex_pkg::TT_IDENT;
  endfunction

  task automatic reset_lexer();
    st = sel_lex_pkg::ST_START;
    pos = '0;
    tok_begin = '0;
    tok_len = '0;
    word_mask = '1;
    word_idx = '0;
    dquote = 1'b0;
    halted = 1'b0;
  endtask

  task automatic match_words(input logic [7:0] c);
    logic [7:0] lc;
    string w;
    int k;
    lc = fold_case(c);
    for (k = 0; k < sel_lex_pkg::NUM_WORDS; k++) begin
      w = reserved[k];
      if (word_idx >= 3'(sel_lex_pkg::WORD_MAXLEN) || int'(word_idx) >= w.len() ||
          w[word_idx] != lc)
        word_mask[k] = 1'b0;
    end
    if (word_idx < 3'(sel_lex_pkg::WORD_MAXLEN)) word_idx++;
  endtask

  task automatic expect_token(input logic [4:0] kind, input logic err,
                              input logic [sel_lex_pkg::OFFSET_BITS-1:0] at,
                              input logic [15:0] span);
    token_t t;
    t.kind = kind;
    t.err = err;
    t.start = 16'(at);
    t.span = span;
    t.last = 1'b0;
    tokens_due = {tokens_due, t};
  endtask

  task automatic start_token(input sel_lex_pkg::lex_state_e s,
                             input logic [sel_lex_pkg::OFFSET_BITS-1:0] at);
    st = s;
    tok_begin = at;
    tok_len = 16'd1;
  endtask

  task automatic count_char();
    if (tok_len != sel_lex_pkg::CNT_MAX) tok_len++;
  endtask

  // lex a character with no token pending
  task automatic open_token(input logic [7:0] c, input logic [sel_lex_pkg::OFFSET_BITS-1:0] at);
    logic [4:0] op;
    op = single_char_op(c);
    if (!blank_ch(c)) begin
      if (op != sel_lex_pkg::TT_END) expect_token(op, 1'b0, at, 16'd1);
      else if (c == "<") start_token(sel_lex_pkg::ST_LT, at);
      else if (c == ">") start_token(sel_lex_pkg::ST_GT, at);
      else if (letter_ch(c) || c == "_" || c == "$") begin
        start_token(sel_lex_pkg::ST_IDENT, at);
        word_mask = '1;
        word_idx = '0;
        match_words(c);
      end else if (c == "'" || c == "\"") begin
        start_token(sel_lex_pkg::ST_STR, at);
        dquote = (c == "\"");
      end else if (c == "0") start_token(sel_lex_pkg::ST_ZERO, at);
      else if (digit_ch(c)) start_token(sel_lex_pkg::ST_DIGIT, at);
      else if (c == ".") start_token(sel_lex_pkg::ST_DEC_START, at);
      else begin
        expect_token(sel_lex_pkg::TT_END, 1'b1, at, 16'd1);
        halted = 1'b1;
      end
    end
  endtask

  // offer a character to the pending token
  task automatic continue_token(input logic [7:0] c, output sel_lex_pkg::pend_act_e act,
                                output logic [4:0] kind);
    logic [7:0] q;
    act = sel_lex_pkg::ACT_TAKE;
    kind = sel_lex_pkg::TT_END;
    q = dquote ? 8'h22 : 8'h27;
    if (st == sel_lex_pkg::ST_ZERO &&
        (c == "." || c == "x" || c == "X" || c == "b" || c == "B")) begin
      if (c == ".") st = sel_lex_pkg::ST_DEC;
      else if (c == "x" || c == "X") st = sel_lex_pkg::ST_HEX_START;
      else st = sel_lex_pkg::ST_BIN_START;
    end else begin
      // a lone leading zero carries on as an octal literal
      if (st == sel_lex_pkg::ST_ZERO) st = sel_lex_pkg::ST_OCT;
      case (st)
        sel_lex_pkg::ST_IDENT: begin
          if (letter_ch(c) || digit_ch(c) || c == "_" || c == "$" || c == ".") match_words(c);
          else begin kind = word_kind(); act = sel_lex_pkg::ACT_NOINC; end
        end
        sel_lex_pkg::ST_LT: begin
          if (c == ">") begin kind = sel_lex_pkg::TT_NE; act = sel_lex_pkg::ACT_INC; end
          else if (c == "=") begin kind = sel_lex_pkg::TT_LE; act = sel_lex_pkg::ACT_INC; end
          else begin kind = sel_lex_pkg::TT_LT; act = sel_lex_pkg::ACT_NOINC; end
        end
        sel_lex_pkg::ST_GT: begin
          if (c == "=") begin kind = sel_lex_pkg::TT_GE; act = sel_lex_pkg::ACT_INC; end
          else begin kind = sel_lex_pkg::TT_GT; act = sel_lex_pkg::ACT_NOINC; end
        end
        sel_lex_pkg::ST_OCT: begin
          if (long_ch(c)) begin kind = sel_lex_pkg::TT_EXACT; act = sel_lex_pkg::ACT_INC; end
          else if (!((c >= "0" && c <= "7") || c == "_")) begin
            kind = sel_lex_pkg::TT_EXACT; act = sel_lex_pkg::ACT_NOINC;
          end
        end
        sel_lex_pkg::ST_DIGIT: begin
          if (long_ch(c)) begin kind = sel_lex_pkg::TT_EXACT; act = sel_lex_pkg::ACT_INC; end
          else if (fd_ch(c)) begin
            kind = sel_lex_pkg::TT_APPROX; act = sel_lex_pkg::ACT_INC;
          end
          else if (digit_ch(c) || c == "_") act = sel_lex_pkg::ACT_TAKE;
          else if (c == ".") st = sel_lex_pkg::ST_DEC;
          else if (c == "e" || c == "E") st = sel_lex_pkg::ST_EXP_SIGN;
          else begin kind = sel_lex_pkg::TT_EXACT; act = sel_lex_pkg::ACT_NOINC; end
        end
        sel_lex_pkg::ST_DEC_START: begin
          if (digit_ch(c)) st = sel_lex_pkg::ST_DEC;
          else act = sel_lex_pkg::ACT_FAIL;
        end
        sel_lex_pkg::ST_DEC: begin
          if (digit_ch(c) || c == "_") act = sel_lex_pkg::ACT_TAKE;
          else if (c == "e" || c == "E") st = sel_lex_pkg::ST_EXP_SIGN;
          else begin
            kind = sel_lex_pkg::TT_APPROX;
            act = fd_ch(c) ? sel_lex_pkg::ACT_INC : sel_lex_pkg::ACT_NOINC;
          end
        end
        sel_lex_pkg::ST_EXP_SIGN: begin
          if (c == "+" || c == "-") st = sel_lex_pkg::ST_EXP_START;
          else if (digit_ch(c)) st = sel_lex_pkg::ST_EXP;
          else act = sel_lex_pkg::ACT_FAIL;
        end
        sel_lex_pkg::ST_EXP_START: begin
          if (digit_ch(c)) st = sel_lex_pkg::ST_EXP;
          else act = sel_lex_pkg::ACT_FAIL;
        end
        sel_lex_pkg::ST_EXP: begin
          if (!digit_ch(c)) begin
            kind = sel_lex_pkg::TT_APPROX;
            act = fd_ch(c) ? sel_lex_pkg::ACT_INC : sel_lex_pkg::ACT_NOINC;
          end
        end
        sel_lex_pkg::ST_HEX_START: begin
          if (hex_ch(c)) st = sel_lex_pkg::ST_HEX;
          else act = sel_lex_pkg::ACT_FAIL;
        end
        sel_lex_pkg::ST_HEX: begin
          if (long_ch(c)) begin kind = sel_lex_pkg::TT_EXACT; act = sel_lex_pkg::ACT_INC; end
          else if (hex_ch(c) || c == "_") act = sel_lex_pkg::ACT_TAKE;
          else if (c == "p" || c == "P") st = sel_lex_pkg::ST_EXP_SIGN;
          else begin kind = sel_lex_pkg::TT_EXACT; act = sel_lex_pkg::ACT_NOINC; end
        end
        sel_lex_pkg::ST_BIN_START: begin
          if (c == "0" || c == "1") st = sel_lex_pkg::ST_BIN;
          else act = sel_lex_pkg::ACT_FAIL;
        end
        sel_lex_pkg::ST_BIN: begin
          if (long_ch(c)) begin kind = sel_lex_pkg::TT_EXACT; act = sel_lex_pkg::ACT_INC; end
          else if (!(c == "0" || c == "1" || c == "_")) begin
            kind = sel_lex_pkg::TT_EXACT; act = sel_lex_pkg::ACT_NOINC;
          end
        end
        sel_lex_pkg::ST_STR: begin
          if (c == q) st = sel_lex_pkg::ST_STR_Q;
        end
        sel_lex_pkg::ST_STR_Q: begin
          // doubled quote stays inside the literal
          if (c == q) st = sel_lex_pkg::ST_STR;
          else begin
            kind = dquote ? sel_lex_pkg::TT_IDENT : sel_lex_pkg::TT_STRING;
            act = sel_lex_pkg::ACT_NOINC;
          end
        end
        default: act = sel_lex_pkg::ACT_FAIL;
      endcase
    end
  endtask

  // one accepted request: character or end of expression
  task automatic lex_request(input logic eoe, input logic [7:0] c);
    logic [sel_lex_pkg::OFFSET_BITS-1:0] here;
    sel_lex_pkg::pend_act_e act;
    logic [4:0] kind;
    logic relex;
    logic broken;
    int due_before;
    here = pos;
    due_before = tokens_due.size();
    if (halted) begin
      if (eoe) reset_lexer();
    end else if (eoe) begin
      broken = 1'b0;
      case (st)
        sel_lex_pkg::ST_START: ;
        sel_lex_pkg::ST_IDENT: expect_token(word_kind(), 1'b0, tok_begin, tok_len);
        sel_lex_pkg::ST_LT: expect_token(sel_lex_pkg::TT_LT, 1'b0, tok_begin, tok_len);
        sel_lex_pkg::ST_GT: expect_token(sel_lex_pkg::TT_GT, 1'b0, tok_begin, tok_len);
        sel_lex_pkg::ST_ZERO, sel_lex_pkg::ST_OCT, sel_lex_pkg::ST_DIGIT,
        sel_lex_pkg::ST_HEX, sel_lex_pkg::ST_BIN:
          expect_token(sel_lex_pkg::TT_EXACT, 1'b0, tok_begin, tok_len);
        sel_lex_pkg::ST_DEC, sel_lex_pkg::ST_EXP:
          expect_token(sel_lex_pkg::TT_APPROX, 1'b0, tok_begin, tok_len);
        sel_lex_pkg::ST_STR_Q:
          expect_token(dquote ? sel_lex_pkg::TT_IDENT : sel_lex_pkg::TT_STRING, 1'b0,
                       tok_begin, tok_len);
        default: begin
          // dangling literal: error instead of the end token
          broken = 1'b1;
          expect_token(sel_lex_pkg::TT_END, 1'b1, tok_begin, tok_len);
        end
      endcase
      if (!broken) expect_token(sel_lex_pkg::TT_END, 1'b0, here, 16'd0);
      reset_lexer();
    end else begin
      relex = 1'b1;
      if (st != sel_lex_pkg::ST_START) begin
        continue_token(c, act, kind);
        relex = 1'b0;
        case (act)
          sel_lex_pkg::ACT_TAKE: count_char();
          sel_lex_pkg::ACT_INC: begin
            count_char();
            expect_token(kind, 1'b0, tok_begin, tok_len);
            st = sel_lex_pkg::ST_START;
          end
          sel_lex_pkg::ACT_NOINC: begin
            expect_token(kind, 1'b0, tok_begin, tok_len);
            st = sel_lex_pkg::ST_START;
            relex = 1'b1;
          end
          default: begin
            count_char();
            expect_token(sel_lex_pkg::TT_END, 1'b1, tok_begin, tok_len);
            st = sel_lex_pkg::ST_START;
            halted = 1'b1;
          end
        endcase
      end
      if (relex) open_token(c, here);
      pos = here + 1'b1;
    end
    if (tokens_due.size() > due_before) begin
      tokens_due[tokens_due.size() - 1].last = 1'b1;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    token_t got;
    token_t want;
    if (!rst_ni) begin
      reset_lexer();
      tokens_due.delete();
    end else begin
      if (req_valid_i && req_ready_i) begin
        lex_request(req_end_i, req_char_i);
        requests++;
      end
      if (res_valid_i && res_ready_i) begin
        got.kind = res_data_i[4:0];
        got.start = res_data_i[20:5];
        got.span = res_data_i[36:21];
        got.err = res_error_i;
        got.last = res_last_i;
        results++;
        if (got.err) error_results++;
        if (tokens_due.size() == 0) begin
          $error("unexpected result: token_type %0d, token_start %0d", got.kind, got.start);
          fails++;
        end else begin
          want = tokens_due.pop_front();
          check_field("token_type", 32'(want.kind), 32'(got.kind));
          check_field("error", 32'(want.err), 32'(got.err));
          check_field("token_start", 32'(want.start), 32'(got.start));
          check_field("token_length", 32'(want.span), 32'(got.span));
          check_field("last", 32'(want.last), 32'(got.last));
        end
      end
    end
    fail_count_o    <= fails;
    pending_o       <= tokens_due.size();
    requests_o      <= requests;
    results_o       <= results;
    error_results_o <= error_results;
  end

endmodule

@@ test/tb_selector_expression_lexer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_selector_expression_lexer_unit
// feeds selector expressions to the lexer one character per request: a short
// directed set, then random well-formed expressions with some noise and cut
// literals; a checker beside the block predicts and compares every token
// ----------------------------------------------------------------------------
module tb_selector_expression_lexer_unit;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int DRAIN_CYCLES    = 12;
  localparam int IDLE_PCT        = 19;
  localparam int RANDOM_REQUESTS = 520;

  localparam string IDENT_HEAD = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_$";
  localparam string IDENT_TAIL =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_$0123456789.";
  localparam string DEC_DIGITS = "0123456789";
  localparam string HEX_DIGITS = "0123456789abcdefABCDEF";
  // space, tab, newline, vertical tab, form feed, carriage return
  localparam string BLANKS     = " \t\n\013\014\015";

  string keywords [11] = '{
    "and", "between", "escape", "false", "in", "is",
    "like", "not", "null", "or", "true"
  };

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  // when set, neither side idles
  logic steady = 1'b0;

  int cycles = 0;
  int sent = 0;
  int fails;
  int pending;
  int requests;
  int results;
  int error_results;

  // characters of the expression being built
  logic [7:0] text [$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  selector_expression_lexer_unit u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  lexer_token_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .req_valid_i     (s_tvalid),
    .req_ready_i     (s_tready),
    .req_char_i      (s_tdata),
    .req_end_i       (s_tuser),
    .res_valid_i     (m_tvalid),
    .res_ready_i     (m_tready),
    .res_data_i      (m_tdata),
    .res_error_i     (m_tuser),
    .res_last_i      (m_tlast),
    .fail_count_o    (fails),
    .pending_o       (pending),
    .requests_o      (requests),
    .results_o       (results),
    .error_results_o (error_results)
  );

  function automatic logic chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic [7:0] pick(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  // result side: random back-pressure, none during the steady stretch
  always @(posedge clk) begin
    m_tready <= steady || !chance(IDLE_PCT);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d tokens still due", cycles, pending);
      $display("FAILURE");
      $finish;
    end
  end

  // present one request and hold it until the block takes it; random idle
  // cycles before it drop tvalid, one assignment per edge
  task automatic send_request(input logic eoe, input logic [7:0] c);
    while (!steady && chance(IDLE_PCT)) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= eoe;
    s_tdata  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic add_char(input logic [7:0] c);
    text = {text, c};
  endtask

  task automatic add_run(string set, int lo, int hi);
    int n;
    n = $urandom_range(lo, hi);
    repeat (n) add_char(pick(set));
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  // built text, then the end mark with a random ignored character
  task automatic send_text();
    for (int i = 0; i < text.size(); i++) send_request(1'b0, text[i]);
    send_request(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_phrase(string s);
    text.delete();
    add_text(s);
    send_text();
  endtask

  // reserved word in mixed case
  task automatic add_keyword();
    string w;
    logic [7:0] c;
    w = keywords[$urandom_range(0, 10)];
    for (int i = 0; i < w.len(); i++) begin
      c = w[i];
      add_char(chance(50) ? c - 8'd32 : c);
    end
  endtask

  task automatic add_exponent(string marks);
    if (chance(40)) begin
      add_char(pick(marks));
      if (chance(50)) add_char(pick("+-"));
      add_run(DEC_DIGITS, 1, 2);
    end
  endtask

  // decimal, octal, hex, binary or bare fraction, with optional suffix
  task automatic add_number();
    case ($urandom_range(0, 4))
      0: begin
        add_char(pick("123456789"));
        add_run("0123456789_", 0, 4);
        if (chance(40)) begin
          add_char(".");
          add_run(DEC_DIGITS, 1, 3);
        end
        add_exponent("eE");
      end
      1: begin
        add_char("0");
        add_run("01234567_", 0, 3);
      end
      2: begin
        add_char("0");
        add_char(pick("xX"));
        add_run(HEX_DIGITS, 1, 1);
        add_run({HEX_DIGITS, "_"}, 0, 3);
        add_exponent("pP");
      end
      3: begin
        add_char("0");
        add_char(pick("bB"));
        add_run("01", 1, 1);
        add_run("01_", 0, 4);
      end
      default: begin
        if (chance(50)) add_char("0");
        add_char(".");
        add_run(DEC_DIGITS, 1, 3);
        add_exponent("eE");
      end
    endcase
    if (chance(30)) add_char(pick("lLfFdD"));
  endtask

  // quoted literal, doubled quotes and arbitrary bytes inside
  task automatic add_quoted();
    logic [7:0] q;
    logic [7:0] c;
    int n;
    q = pick("'\"");
    add_char(q);
    n = $urandom_range(0, 6);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: begin
          add_char(q);
          add_char(q);
        end
        1: begin
          c = 8'($urandom_range(0, 255));
          add_char(c);
          if (c == q) add_char(q);
        end
        default: add_char(pick({IDENT_HEAD, " "}));
      endcase
    end
    add_char(q);
  endtask

  task automatic add_token();
    case ($urandom_range(0, 19))
      0, 1, 2, 3: begin
        add_keyword();
        // sometimes a keyword prefix of a longer identifier
        if (chance(20)) add_run(IDENT_TAIL, 1, 3);
      end
      4, 5, 6: begin
        add_char(pick(IDENT_HEAD));
        add_run(IDENT_TAIL, 0, chance(10) ? 12 : 5);
      end
      7, 8, 9: begin
        case ($urandom_range(0, 2))
          0: add_char(pick("(),+-*/="));
          1: begin
            add_char("<");
            if (chance(66)) add_char(pick("=>"));
          end
          default: begin
            add_char(">");
            if (chance(50)) add_char("=");
          end
        endcase
      end
      10, 11, 12, 13, 14: add_number();
      15, 16, 17, 18: add_quoted();
      // noise: any byte, often illegal
      default: add_char(8'($urandom_range(0, 255)));
    endcase
  endtask

  // random expression: tokens, sometimes separated, sometimes cut short
  task automatic send_random_expression();
    int n;
    text.delete();
    n = $urandom_range(1, 8);
    repeat (n) begin
      add_token();
      if (chance(50)) add_run(BLANKS, 1, 2);
    end
    if (chance(8)) begin
      n = $urandom_range(1, 3);
      repeat (n) if (text.size() > 0) text.delete(text.size() - 1);
    end
    send_text();
  endtask

  initial begin
    int random_base;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty expression: end token only
    send_phrase("");
    // every operator, with lookahead cases back to back
    send_phrase("(),+-*/=<<=<>>>=");
    // reserved words in mixed case, an over-long one and dotted identifier
    send_phrase("AND between Escape fALSe in IS like NOT nuLL or TRUE betweens x.y_$9");
    // strings with doubled quotes, quoted identifier and every number form
    send_phrase("'it''s' \"q\"\"x\" 0x1fp-3d 0Xa_bL 0b1_0L 017l 08 1.5e+2F .5 9L 12d 3e4");
    // illegal character halts until the end mark
    send_phrase("a#b");
    // malformed hex prefix
    send_phrase("0x;");
    // dangling exponent and dangling string at the end mark
    send_phrase("1e+");
    send_phrase("'abc");
    // pending operator flushed by the end mark
    send_phrase("x <");
    // top byte value is illegal
    send_request(1'b0, 8'hFF);
    send_request(1'b1, 8'hFF);

    random_base = sent;
    while (sent - random_base < RANDOM_REQUESTS) begin
      steady = (sent - random_base >= 250) && (sent - random_base < 400);
      send_random_expression();
    end
    steady = 1'b0;

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("lexed %0d requests of directed and random expressions into %0d tokens,",
             requests, results);
    $display("%0d of them error results, under random stalls on both sides", error_results);
    if (fails == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/sel_lex_pkg.sv
design/sel_lex_words.sv
design/sel_lex_core.sv
design/sel_lex_fifo.sv
design/selector_expression_lexer_unit.sv
test/lexer_token_checker.sv
test/tb_selector_expression_lexer_unit.sv
